// File: rtl/mae_pkg.sv
// Package: shared types, codes and rate tables of the multichannel ADSR envelope.
package mae_pkg;

  // Event applied before the envelope step
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOTEOFF = 2'd3
  } op_e;

  // Envelope phase; codes 5..7 are never produced and act as off
  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  localparam logic [11:0] FULL_LEVEL = 12'h F00;

  // One tick item, last field in the lowest bits
  typedef struct packed {
    logic [3:0] instrument;
    logic [7:0] sustain_release_code;
    logic [7:0] attack_decay_code;
    logic [1:0] channel;
    logic [1:0] opcode;
  } tick_t;

  // One result item, last field in the lowest bits
  typedef struct packed {
    logic        silenced;
    logic [11:0] level;
    logic [2:0]  phase;
    logic [3:0]  volume;
    logic [1:0]  voice;
  } result_t;

  localparam int TICK_W   = $bits(tick_t);
  localparam int RESULT_W = $bits(result_t);
  localparam int IN_DW    = ((TICK_W + 7) / 8) * 8;
  localparam int OUT_DW   = ((RESULT_W + 7) / 8) * 8;

  // Attack rate per nibble
  function automatic logic [11:0] attack_rate(input logic [3:0] code);
    logic [11:0] r;
    case (code)
      4'd0:    r = 12'h F00;
      4'd1:    r = 12'h F00;
      4'd2:    r = 12'h F00;
      4'd3:    r = 12'h C80;
      4'd4:    r = 12'h 7E5;
      4'd5:    r = 12'h 55B;
      4'd6:    r = 12'h 469;
      4'd7:    r = 12'h 3C0;
      4'd8:    r = 12'h 300;
      4'd9:    r = 12'h 133;
      4'd10:   r = 12'h 09A;
      4'd11:   r = 12'h 060;
      4'd12:   r = 12'h 04D;
      4'd13:   r = 12'h 01A;
      4'd14:   r = 12'h 00F;
      default: r = 12'h 00A;
    endcase
    return r;
  endfunction

  // Decay and release rate per nibble
  function automatic logic [11:0] fall_rate(input logic [3:0] code);
    logic [11:0] r;
    case (code)
      4'd0:    r = 12'h F00;
      4'd1:    r = 12'h C80;
      4'd2:    r = 12'h 640;
      4'd3:    r = 12'h 42B;
      4'd4:    r = 12'h 2A2;
      4'd5:    r = 12'h 1C9;
      4'd6:    r = 12'h 178;
      4'd7:    r = 12'h 140;
      4'd8:    r = 12'h 100;
      4'd9:    r = 12'h 066;
      4'd10:   r = 12'h 033;
      4'd11:   r = 12'h 020;
      4'd12:   r = 12'h 01A;
      4'd13:   r = 12'h 009;
      4'd14:   r = 12'h 005;
      default: r = 12'h 003;
    endcase
    return r;
  endfunction

  // Volume scale per instrument modulo 8
  function automatic logic [3:0] vol_scale(input logic [2:0] inst);
    logic [3:0] s;
    case (inst)
      3'd0:    s = 4'd13;
      3'd1:    s = 4'd11;
      3'd2:    s = 4'd10;
      3'd3:    s = 4'd11;
      3'd4:    s = 4'd13;
      3'd5:    s = 4'd13;
      3'd6:    s = 4'd14;
      default: s = 4'd12;
    endcase
    return s;
  endfunction

  // (hi * scale) / 15 via reciprocal: x * 137 >> 11 is exact for x <= 225
  function automatic logic [3:0] vol_calc(input logic [3:0] hi, input logic [2:0] inst);
    logic [7:0]  prod;
    logic [15:0] recip;
    prod  = hi * vol_scale(inst);
    recip = {8'd0, prod} * 16'd137;
    return recip[14:11];
  endfunction

endpackage

// File: rtl/multichannel_adsr_envelope.sv
// Top level: input register, voice bank step and result register.
// A tick is held first in the input register and then in the result register.
// Throughput: one tick per cycle; the input register and the result register
// form a two-entry pipeline with a common stall on the result side.
// Reset clears all voice state to level zero, phase off, and empties both
// pipeline registers.
module multichannel_adsr_envelope #(
  parameter int VOICES = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [1:0] opcode, [3:2] channel, [11:4] attack_decay_code,
  // [19:12] sustain_release_code, [23:20] instrument
  input  logic [mae_pkg::IN_DW-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [1:0] voice, [5:2] volume, [8:6] phase, [20:9] level, [21] silenced, [23:22] zero
  output logic [mae_pkg::OUT_DW-1:0] m_axis_tdata
);

  logic             s1_valid_q;
  mae_pkg::tick_t   s1_tick_q;
  logic             m_valid_q;
  mae_pkg::result_t m_res_q;
  mae_pkg::result_t res;
  logic             advance;
  logic             s_xfer;

  assign advance       = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      s1_tick_q <= mae_pkg::tick_t'(s_axis_tdata[mae_pkg::TICK_W-1:0]);
    end
  end

  mae_voice_bank #(
    .VOICES(VOICES)
  ) u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_en_i (s1_valid_q && advance),
    .tick_i   (s1_tick_q),
    .res_o    (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = mae_pkg::OUT_DW'(m_res_q);

`ifndef SYNTHESIS
  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> m_res_q.level <= mae_pkg::FULL_LEVEL)
    else $error("level above full scale");

  a_volume_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> m_res_q.volume <= 4'd14)
    else $error("volume out of range");

  a_silenced_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_res_q.silenced) |->
      (m_res_q.phase == mae_pkg::PH_OFF && m_res_q.level == '0))
    else $error("silenced voice not off at zero level");

  a_unknown_voice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && int'(m_res_q.voice) >= VOICES) |->
      (m_res_q.volume == '0 && m_res_q.phase == '0 && m_res_q.level == '0
       && !m_res_q.silenced))
    else $error("unknown voice reported nonzero result");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_valid_q |-> s_axis_tready)
    else $error("input stalled with empty result register");
`endif

endmodule

// File: rtl/mae_voice_bank.sv
// Per-voice envelope state and the single-pass event and envelope step.
module mae_voice_bank #(
  parameter int VOICES = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_en_i,
  input  mae_pkg::tick_t   tick_i,
  output mae_pkg::result_t res_o
);

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  mae_pkg::phase_e phase_q  [VOICES];
  logic [11:0]     level_q  [VOICES];
  logic [11:0]     att_q    [VOICES];
  logic [11:0]     dec_q    [VOICES];
  logic [11:0]     rel_q    [VOICES];
  logic [3:0]      sus_q    [VOICES];

  logic [IDX_W-1:0] idx;
  logic             in_range;
  mae_pkg::phase_e  ph_ev, ph_n;
  logic [11:0]      lvl_ev, lvl_n;
  logic [11:0]      att_n, dec_n, rel_n, tgt;
  logic [3:0]       sus_n;
  logic [12:0]      sum, lim;
  logic             sil;

  assign idx      = IDX_W'(tick_i.channel);
  assign in_range = int'(tick_i.channel) < VOICES;

  // Event, then one envelope step for the addressed voice
  always_comb begin
    ph_ev  = phase_q[idx];
    lvl_ev = level_q[idx];
    att_n  = att_q[idx];
    dec_n  = dec_q[idx];
    rel_n  = rel_q[idx];
    sus_n  = sus_q[idx];
    sil    = 1'b0;
    case (mae_pkg::op_e'(tick_i.opcode))
      mae_pkg::OP_TRIGGER: begin
        ph_ev = mae_pkg::PH_ATTACK;
        att_n = mae_pkg::attack_rate(tick_i.attack_decay_code[7:4]);
        dec_n = mae_pkg::fall_rate(tick_i.attack_decay_code[3:0]);
        sus_n = tick_i.sustain_release_code[7:4];
        rel_n = mae_pkg::fall_rate(tick_i.sustain_release_code[3:0]);
      end
      mae_pkg::OP_RELEASE: begin
        if (ph_ev != mae_pkg::PH_OFF && ph_ev != mae_pkg::PH_RELEASE) begin
          ph_ev = mae_pkg::PH_RELEASE;
        end
      end
      mae_pkg::OP_NOTEOFF: begin
        ph_ev  = mae_pkg::PH_OFF;
        lvl_ev = '0;
        sil    = 1'b1;
      end
      default: ;
    endcase

    tgt   = {sus_n, 8'd0};
    sum   = {1'b0, lvl_ev} + {1'b0, att_n};
    lim   = {1'b0, dec_n} + {1'b0, tgt};
    ph_n  = ph_ev;
    lvl_n = lvl_ev;
    case (ph_ev)
      mae_pkg::PH_ATTACK: begin
        if (sum >= {1'b0, mae_pkg::FULL_LEVEL}) begin
          lvl_n = mae_pkg::FULL_LEVEL;
          ph_n  = mae_pkg::PH_DECAY;
        end else begin
          lvl_n = sum[11:0];
        end
      end
      mae_pkg::PH_DECAY: begin
        if ({1'b0, lvl_ev} > lim) begin
          lvl_n = lvl_ev - dec_n;
        end else begin
          lvl_n = tgt;
          ph_n  = mae_pkg::PH_SUSTAIN;
        end
      end
      mae_pkg::PH_SUSTAIN: ;
      mae_pkg::PH_RELEASE: begin
        if (lvl_ev > rel_n) begin
          lvl_n = lvl_ev - rel_n;
        end else begin
          lvl_n = '0;
          ph_n  = mae_pkg::PH_OFF;
          sil   = 1'b1;
        end
      end
      default: begin
        lvl_n = '0;
        ph_n  = mae_pkg::PH_OFF;
      end
    endcase
  end

  // Result; an unknown voice reports its channel with all other fields zero
  always_comb begin
    res_o.voice = tick_i.channel;
    if (in_range) begin
      res_o.volume   = mae_pkg::vol_calc(lvl_n[11:8], tick_i.instrument[2:0]);
      res_o.phase    = ph_n;
      res_o.level    = lvl_n;
      res_o.silenced = sil;
    end else begin
      res_o.volume   = '0;
      res_o.phase    = '0;
      res_o.level    = '0;
      res_o.silenced = 1'b0;
    end
  end

  // Voice state write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < VOICES; v++) begin
        phase_q[v] <= mae_pkg::PH_OFF;
        level_q[v] <= '0;
        att_q[v]   <= '0;
        dec_q[v]   <= '0;
        rel_q[v]   <= '0;
        sus_q[v]   <= '0;
      end
    end else if (upd_en_i && in_range) begin
      phase_q[idx] <= ph_n;
      level_q[idx] <= lvl_n;
      att_q[idx]   <= att_n;
      dec_q[idx]   <= dec_n;
      rel_q[idx]   <= rel_n;
      sus_q[idx]   <= sus_n;
    end
  end

endmodule
